// ===== rtl/kda_pkg.sv =====
package kda_pkg;

   // register map (index, byte address is 4 * index)
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LOW    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_REPORT_CODE   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PRESS_COUNT   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_REPEAT_COUNT  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_RELEASE_COUNT = 3'd5;

   // field widths
   localparam int CODE_W   = 10;
   localparam int PERIOD_W = 16;
   localparam int THRESH_W = 8;

   // reset values
   localparam logic                RST_ACTIVE_LOW    = 1'b1;
   localparam logic [CODE_W-1:0]   RST_REPORT_CODE   = 10'd0;
   localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD = 16'd20;
   localparam logic [THRESH_W-1:0] RST_PRESS_COUNT   = 8'd6;
   localparam logic [THRESH_W-1:0] RST_REPEAT_COUNT  = 8'd18;
   localparam logic [THRESH_W-1:0] RST_RELEASE_COUNT = 8'd6;

   // default parameter values
   localparam int DEF_COUNT_BITS  = 8;
   localparam int DEF_PERIOD_BITS = 16;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_REPEAT  = 2'd2,
      EV_RELEASE = 2'd3
   } kda_event_type;

   typedef struct packed {
      logic                active_low;
      logic [CODE_W-1:0]   report_code;
      logic [PERIOD_W-1:0] sample_period;
      logic [THRESH_W-1:0] press_count;
      logic [THRESH_W-1:0] repeat_count;
      logic [THRESH_W-1:0] release_count;
   } kda_cfg_type;

endpackage

// ===== rtl/key_debounce_autorepeat_core.sv =====
// Debouncer with autorepeat for one key pin. Send one req word per base tick
// (normally 1 ms) carrying the raw pin level; each req word yields exactly one
// rsp word, carrying the event kind (none, press, repeat, release) and the
// configured key code, or zero code when there is no event. A rising edge into
// the active level restarts a sample timer of sample_period ticks; each expiry
// takes one sample, and press, repeat and release are reported when the
// active/inactive sample counters hit their configured thresholds. The block
// takes one word per clock cycle unless the rsp side stalls: a word sits in the
// input register while the counter and timer update runs, then appears in the
// output register. Configuration registers over the csr port should be
// written only while no word is in flight.
module key_debounce_autorepeat_core #(
   parameter int COUNT_BITS  = kda_pkg::DEF_COUNT_BITS,   // sample counter width
   parameter int PERIOD_BITS = kda_pkg::DEF_PERIOD_BITS   // sample timer width
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [0] pin_level, [7:1] zero
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // [9:0] event_code, [15:10] zero
   output logic [1:0]                      rsp_tuser,   // [1:0] event_kind
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [kda_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [kda_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [kda_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   kda_pkg::kda_cfg_type    cfg;
   kda_pkg::kda_event_type  kind;

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic                         in_pin_ff, in_pin_in;
   // output register
   logic                         out_valid_ff, out_valid_in;
   kda_pkg::kda_event_type       out_kind_ff, out_kind_in;
   logic [kda_pkg::CODE_W-1:0]   out_code_ff, out_code_in;

   logic                         advance;

   // word moves from input register to output register when the output
   // register is empty or being drained this cycle
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   kda_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // timer, counters and event decision, updated once per advanced word
   kda_engine #(
      .COUNT_BITS  (COUNT_BITS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (advance),
      .pin   (in_pin_ff),
      .kind  (kind)
   );

   always_comb begin
      // input register
      in_valid_in = in_valid_ff;
      in_pin_in   = in_pin_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_pin_in   = req_tdata[0];
      end
      // output register
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_code_in  = out_code_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_kind_in  = kind;
         out_code_in  = (kind != kda_pkg::EV_NONE) ? cfg.report_code : '0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_pin_ff   <= in_pin_in;
      out_kind_ff <= out_kind_in;
      out_code_ff <= out_code_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = 16'(out_code_ff);

   a_none_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_kind_ff == kda_pkg::EV_NONE |-> out_code_ff == '0)
      else $error("code present without an event");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word lost");

endmodule

// ===== rtl/kda_csr.sv =====
module kda_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [kda_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [kda_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [kda_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output kda_pkg::kda_cfg_type                cfg
);

   kda_pkg::kda_cfg_type           cfg_ff;
   kda_pkg::kda_cfg_type           cfg_in;
   logic                           wr_en;
   logic [kda_pkg::REG_IDX_W-1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[kda_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            kda_pkg::REG_ACTIVE_LOW:    cfg_in.active_low = csr_pwdata[0];
            kda_pkg::REG_REPORT_CODE:
               cfg_in.report_code = csr_pwdata[kda_pkg::CODE_W-1:0];
            kda_pkg::REG_SAMPLE_PERIOD:
               cfg_in.sample_period = csr_pwdata[kda_pkg::PERIOD_W-1:0];
            kda_pkg::REG_PRESS_COUNT:
               cfg_in.press_count = csr_pwdata[kda_pkg::THRESH_W-1:0];
            kda_pkg::REG_REPEAT_COUNT:
               cfg_in.repeat_count = csr_pwdata[kda_pkg::THRESH_W-1:0];
            kda_pkg::REG_RELEASE_COUNT:
               cfg_in.release_count = csr_pwdata[kda_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low    <= kda_pkg::RST_ACTIVE_LOW;
         cfg_ff.report_code   <= kda_pkg::RST_REPORT_CODE;
         cfg_ff.sample_period <= kda_pkg::RST_SAMPLE_PERIOD;
         cfg_ff.press_count   <= kda_pkg::RST_PRESS_COUNT;
         cfg_ff.repeat_count  <= kda_pkg::RST_REPEAT_COUNT;
         cfg_ff.release_count <= kda_pkg::RST_RELEASE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         kda_pkg::REG_ACTIVE_LOW:    csr_prdata = kda_pkg::CSR_DATA_W'(cfg_ff.active_low);
         kda_pkg::REG_REPORT_CODE:   csr_prdata = kda_pkg::CSR_DATA_W'(cfg_ff.report_code);
         kda_pkg::REG_SAMPLE_PERIOD: csr_prdata = kda_pkg::CSR_DATA_W'(cfg_ff.sample_period);
         kda_pkg::REG_PRESS_COUNT:   csr_prdata = kda_pkg::CSR_DATA_W'(cfg_ff.press_count);
         kda_pkg::REG_REPEAT_COUNT:  csr_prdata = kda_pkg::CSR_DATA_W'(cfg_ff.repeat_count);
         kda_pkg::REG_RELEASE_COUNT: csr_prdata = kda_pkg::CSR_DATA_W'(cfg_ff.release_count);
         default:                    csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/kda_engine.sv =====
module kda_engine #(
   parameter int COUNT_BITS  = kda_pkg::DEF_COUNT_BITS,
   parameter int PERIOD_BITS = kda_pkg::DEF_PERIOD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kda_pkg::kda_cfg_type  cfg,
   input  logic                  step,
   input  logic                  pin,
   output kda_pkg::kda_event_type kind
);

   // compare width covers both the counters and the 8-bit thresholds
   localparam int CMP_W = (COUNT_BITS > kda_pkg::THRESH_W) ? COUNT_BITS : kda_pkg::THRESH_W;

   logic                   last_active_ff, last_active_in;
   logic                   armed_ff, armed_in;
   logic [PERIOD_BITS-1:0] ticks_ff, ticks_in;
   logic                   engaged_ff, engaged_in;
   logic [COUNT_BITS-1:0]  act_ff, act_in;
   logic [COUNT_BITS-1:0]  inact_ff, inact_in;

   logic                   active;
   logic                   rise;
   logic                   expiry;
   logic [PERIOD_BITS-1:0] reload;
   logic [CMP_W:0]         press_plus;

   assign active     = cfg.active_low ? ~pin : pin;
   assign rise       = active & ~last_active_ff;
   assign expiry     = armed_ff & (ticks_ff <= PERIOD_BITS'(1));
   assign reload     = PERIOD_BITS'(cfg.sample_period);
   assign press_plus = (CMP_W+1)'(cfg.press_count) + (CMP_W+1)'(1);

   always_comb begin
      last_active_in = last_active_ff;
      armed_in       = armed_ff;
      ticks_in       = ticks_ff;
      engaged_in     = engaged_ff;
      act_in         = act_ff;
      inact_in       = inact_ff;
      kind           = kda_pkg::EV_NONE;
      if (step) begin
         last_active_in = active;
         // timer countdown
         if (armed_ff) begin
            if (expiry) begin
               armed_in = 1'b0;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_ff - PERIOD_BITS'(1);
            end
         end
         if (rise) begin
            armed_in = 1'b1;
            ticks_in = reload;
         end else if (expiry) begin
            if (active)
               engaged_in = 1'b1;
            if (engaged_in) begin
               if (active)
                  act_in = act_ff + COUNT_BITS'(1);
               else
                  inact_in = inact_ff + COUNT_BITS'(1);
               if (CMP_W'(inact_in) != CMP_W'(cfg.release_count)) begin
                  armed_in = 1'b1;
                  ticks_in = reload;
               end
               if (CMP_W'(act_in) == CMP_W'(cfg.press_count)) begin
                  act_in = act_in + COUNT_BITS'(1);
                  kind   = kda_pkg::EV_PRESS;
               end else if (CMP_W'(act_in) == CMP_W'(cfg.repeat_count)) begin
                  act_in   = COUNT_BITS'(press_plus);
                  inact_in = '0;
                  kind     = kda_pkg::EV_REPEAT;
               end else if (CMP_W'(inact_in) == CMP_W'(cfg.release_count)) begin
                  act_in     = '0;
                  inact_in   = '0;
                  engaged_in = 1'b0;
                  kind       = kda_pkg::EV_RELEASE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_active_ff <= 1'b0;
         armed_ff       <= 1'b1;
         ticks_ff       <= PERIOD_BITS'(kda_pkg::RST_SAMPLE_PERIOD);
         engaged_ff     <= 1'b0;
         act_ff         <= '0;
         inact_ff       <= '0;
      end else begin
         last_active_ff <= last_active_in;
         armed_ff       <= armed_in;
         ticks_ff       <= ticks_in;
         engaged_ff     <= engaged_in;
         act_ff         <= act_in;
         inact_ff       <= inact_in;
      end
   end

   a_release_disengages: assert property (@(posedge clock) disable iff (reset)
      step && kind == kda_pkg::EV_RELEASE |=> !engaged_ff)
      else $error("engine still engaged after release");

   a_press_engaged: assert property (@(posedge clock) disable iff (reset)
      step && (kind == kda_pkg::EV_PRESS || kind == kda_pkg::EV_REPEAT) |=> engaged_ff)
      else $error("press or repeat without engagement");

   a_idle_timer_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> ticks_ff == '0)
      else $error("disarmed timer holds a count");

   a_event_needs_expiry: assert property (@(posedge clock) disable iff (reset)
      step && kind != kda_pkg::EV_NONE |-> expiry && !rise)
      else $error("event outside a sample expiry");

endmodule

// ===== bench/tb_key_debounce_autorepeat_core.sv =====
module tb_key_debounce_autorepeat_core;
   timeunit 1ns;
   timeprecision 1ps;

   // register slot past the end of the map, writes there must be dropped
   localparam logic [kda_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd6;

   // shape of the random settings used by one phase
   typedef enum int {
      PROF_SHORT,     // short period, press below repeat
      PROF_SKEWED,    // repeat may sit at or below press
      PROF_FLOOR,     // lowest thresholds, zero period
      PROF_CEILING,   // highest thresholds, counters wrap
      PROF_SLOW,      // several ticks between samples
      PROF_LONGEST    // longest period, timer never runs out
   } profile_type;

   // receiver back-pressure moods
   typedef enum int {
      RX_STEADY,
      RX_CHOPPY,
      RX_CRAWL
   } rx_mood_type;

   typedef struct packed {
      kda_pkg::kda_event_type     kind;
      logic [kda_pkg::CODE_W-1:0] code;
   } key_event_type;

   logic clock;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;    // [0] pin_level, [7:1] zero
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [15:0]                    rsp_tdata;         // [9:0] event_code, [15:10] zero
   logic [1:0]                     rsp_tuser;         // [1:0] event_kind
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [kda_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [kda_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [kda_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   key_debounce_autorepeat_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // --------------------------------------------------------------------
   // predictor: mirror of the settings and of the debounce state
   // --------------------------------------------------------------------
   kda_pkg::kda_cfg_type key_cfg = '{kda_pkg::RST_ACTIVE_LOW, kda_pkg::RST_REPORT_CODE,
                                     kda_pkg::RST_SAMPLE_PERIOD, kda_pkg::RST_PRESS_COUNT,
                                     kda_pkg::RST_REPEAT_COUNT, kda_pkg::RST_RELEASE_COUNT};

   logic                         key_was_active  = 1'b0;
   logic                         timer_running   = 1'b1;   // timer starts armed out of reset
   logic [kda_pkg::PERIOD_W-1:0] ticks_to_sample = kda_pkg::RST_SAMPLE_PERIOD;
   logic                         key_held        = 1'b0;
   logic [kda_pkg::THRESH_W-1:0] down_samples    = '0;
   logic [kda_pkg::THRESH_W-1:0] up_samples      = '0;

   // advance the debounce state by one base tick, return the event it raises
   function automatic kda_pkg::kda_event_type debounce_step(input logic pin);
      logic                   active;
      logic                   rising;
      logic                   expired;
      kda_pkg::kda_event_type kind;
      active  = key_cfg.active_low ? !pin : pin;
      rising  = active && !key_was_active;
      expired = 1'b0;
      kind    = kda_pkg::EV_NONE;
      key_was_active = active;

      // one-shot timer, a count of one or zero runs out this tick
      if (timer_running) begin
         if (ticks_to_sample <= 1) begin
            expired         = 1'b1;
            timer_running   = 1'b0;
            ticks_to_sample = '0;
         end else begin
            ticks_to_sample = ticks_to_sample - 1'b1;
         end
      end

      // an edge beats an expiry in the same tick: reload, no sample
      if (rising) begin
         timer_running   = 1'b1;
         ticks_to_sample = key_cfg.sample_period;
      end else if (expired) begin
         if (active)
            key_held = 1'b1;
         if (key_held) begin
            if (active)
               down_samples = down_samples + 1'b1;
            else
               up_samples = up_samples + 1'b1;
            // timer stops once the release count is reached
            if (up_samples != key_cfg.release_count) begin
               timer_running   = 1'b1;
               ticks_to_sample = key_cfg.sample_period;
            end
            // only one event per sample, press first, then repeat, then release
            if (down_samples == key_cfg.press_count) begin
               down_samples = down_samples + 1'b1;
               kind = kda_pkg::EV_PRESS;
            end else if (down_samples == key_cfg.repeat_count) begin
               down_samples = key_cfg.press_count + 1'b1;
               up_samples   = '0;
               kind = kda_pkg::EV_REPEAT;
            end else if (up_samples == key_cfg.release_count) begin
               up_samples   = '0;
               down_samples = '0;
               key_held     = 1'b0;
               kind = kda_pkg::EV_RELEASE;
            end
         end
      end
      return kind;
   endfunction

   // --------------------------------------------------------------------
   // bookkeeping shared by the driver, the monitor and the sequencer
   // --------------------------------------------------------------------
   logic          pin_backlog[$];        // pin levels waiting to be sent
   key_event_type predicted_events[$];   // events owed by the block, oldest first
   int unsigned   words_queued   = 0;
   int unsigned   words_accepted = 0;
   int unsigned   mismatch_count = 0;

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: mismatch on %s, expected %h, got %h", $realtime, what, want, got);
   endfunction

   // --------------------------------------------------------------------
   // driver: bursts of words with random gaps in between
   // --------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin : driver
      logic          presenting;
      key_event_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         presenting = req_tvalid;
         // word taken at this edge: predict its event right away
         if (req_tvalid && req_tready) begin
            ev.kind = debounce_step(req_tdata[0]);
            ev.code = (ev.kind != kda_pkg::EV_NONE) ? key_cfg.report_code : '0;
            predicted_events.push_back(ev);
            words_accepted++;
            presenting = 1'b0;
         end
         // a word still waiting keeps tvalid and tdata as they are
         if (!presenting) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pin_backlog.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, pin_backlog.pop_front()};
               // burst over: pick the next one, a third of them follow back to back
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // monitor: receiver stalls follow a mood that is redrawn at random, each for a random span of cycles
   // --------------------------------------------------------------------
   rx_mood_type rx_mood   = RX_STEADY;
   int unsigned rx_window = 0;
   int unsigned rx_cycle  = 0;

   always @(posedge clock) begin : monitor
      key_event_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_events.size() == 0) begin
               note_mismatch("word with nothing predicted", 32'd0, {14'd0, rsp_tuser, rsp_tdata});
            end else begin
               want = predicted_events.pop_front();
               if (rsp_tuser !== want.kind)
                  note_mismatch("event kind", 32'(want.kind), 32'(rsp_tuser));
               if (rsp_tdata !== {6'd0, want.code})
                  note_mismatch("event code", 32'(want.code), 32'(rsp_tdata));
            end
         end

         rx_cycle++;
         if (rx_window == 0) begin
            rx_mood   = rx_mood_type'($urandom_range(0, 2));
            rx_window = $urandom_range(16, 96);
         end else begin
            rx_window--;
         end
         case (rx_mood)
            RX_STEADY: rsp_tready <= 1'b1;
            RX_CHOPPY: rsp_tready <= ($urandom_range(0, 2) != 0);
            default:   rsp_tready <= (rx_cycle % 4 == 0);   // one cycle in four
         endcase
      end
   end

   // --------------------------------------------------------------------
   // register access
   // --------------------------------------------------------------------
   function automatic logic [31:0] register_image(input logic [kda_pkg::REG_IDX_W-1:0] idx);
      case (idx)
         kda_pkg::REG_ACTIVE_LOW:    return 32'(key_cfg.active_low);
         kda_pkg::REG_REPORT_CODE:   return 32'(key_cfg.report_code);
         kda_pkg::REG_SAMPLE_PERIOD: return 32'(key_cfg.sample_period);
         kda_pkg::REG_PRESS_COUNT:   return 32'(key_cfg.press_count);
         kda_pkg::REG_REPEAT_COUNT:  return 32'(key_cfg.repeat_count);
         kda_pkg::REG_RELEASE_COUNT: return 32'(key_cfg.release_count);
         default:                    return '0;
      endcase
   endfunction

   // setup cycle, then access cycle until pready
   task automatic csr_write(input logic [kda_pkg::REG_IDX_W-1:0] idx,
                            input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // the slot past the map is ignored
      case (idx)
         kda_pkg::REG_ACTIVE_LOW:    key_cfg.active_low    = value[0];
         kda_pkg::REG_REPORT_CODE:   key_cfg.report_code   = value[kda_pkg::CODE_W-1:0];
         kda_pkg::REG_SAMPLE_PERIOD: key_cfg.sample_period = value[kda_pkg::PERIOD_W-1:0];
         kda_pkg::REG_PRESS_COUNT:   key_cfg.press_count   = value[kda_pkg::THRESH_W-1:0];
         kda_pkg::REG_REPEAT_COUNT:  key_cfg.repeat_count  = value[kda_pkg::THRESH_W-1:0];
         kda_pkg::REG_RELEASE_COUNT: key_cfg.release_count = value[kda_pkg::THRESH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic check_registers();
      logic [31:0] got;
      for (int r = kda_pkg::REG_ACTIVE_LOW; r <= kda_pkg::REG_RELEASE_COUNT; r++) begin
         @(posedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         csr_paddr   <= {kda_pkg::REG_IDX_W'(r), 2'b00};
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         got = csr_prdata;
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         if (got !== register_image(kda_pkg::REG_IDX_W'(r)))
            note_mismatch($sformatf("register %0d read back", r),
                          register_image(kda_pkg::REG_IDX_W'(r)), got);
      end
   endtask

   task automatic program_registers(input kda_pkg::kda_cfg_type c);
      csr_write(kda_pkg::REG_ACTIVE_LOW,    32'(c.active_low));
      csr_write(kda_pkg::REG_REPORT_CODE,   32'(c.report_code));
      csr_write(kda_pkg::REG_SAMPLE_PERIOD, 32'(c.sample_period));
      csr_write(kda_pkg::REG_PRESS_COUNT,   32'(c.press_count));
      csr_write(kda_pkg::REG_REPEAT_COUNT,  32'(c.repeat_count));
      csr_write(kda_pkg::REG_RELEASE_COUNT, 32'(c.release_count));
      check_registers();
   endtask

   // --------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------
   function automatic void queue_pin(input logic level);
      pin_backlog.push_back(level);
      words_queued++;
   endfunction

   // pin levels, lowest bit sent first
   function automatic void queue_bits(input logic [31:0] bits, input int unsigned n);
      for (int unsigned k = 0; k < n; k++)
         queue_pin(bits[k]);
   endfunction

   function automatic void queue_chatter();
      repeat ($urandom_range(0, 4)) queue_pin(1'($urandom_range(0, 1)));
   endfunction

   function automatic kda_pkg::kda_cfg_type pick_settings(input profile_type profile);
      kda_pkg::kda_cfg_type c;
      c.active_low  = 1'($urandom_range(0, 1));
      c.report_code = kda_pkg::CODE_W'($urandom_range(0, 1023));
      case (profile)
         PROF_SHORT: begin
            c.sample_period = kda_pkg::PERIOD_W'($urandom_range(0, 3));
            c.press_count   = kda_pkg::THRESH_W'($urandom_range(1, 6));
            c.repeat_count  = c.press_count + kda_pkg::THRESH_W'($urandom_range(1, 6));
            c.release_count = kda_pkg::THRESH_W'($urandom_range(1, 6));
         end
         PROF_SKEWED: begin
            c.sample_period = kda_pkg::PERIOD_W'($urandom_range(0, 2));
            c.press_count   = kda_pkg::THRESH_W'($urandom_range(1, 8));
            c.repeat_count  = kda_pkg::THRESH_W'($urandom_range(2, 8));
            c.release_count = kda_pkg::THRESH_W'($urandom_range(1, 4));
         end
         PROF_FLOOR: begin
            c.sample_period = '0;
            c.press_count   = 8'd1;
            c.repeat_count  = 8'd2;
            c.release_count = 8'd1;
         end
         PROF_CEILING: begin
            c.report_code   = '1;
            c.sample_period = kda_pkg::PERIOD_W'($urandom_range(0, 1));
            c.press_count   = 8'd254;
            c.repeat_count  = 8'd255;
            c.release_count = 8'd255;
         end
         PROF_SLOW: begin
            c.sample_period = kda_pkg::PERIOD_W'($urandom_range(4, 9));
            c.press_count   = kda_pkg::THRESH_W'($urandom_range(1, 4));
            c.repeat_count  = c.press_count + kda_pkg::THRESH_W'($urandom_range(1, 4));
            c.release_count = kda_pkg::THRESH_W'($urandom_range(1, 4));
         end
         default: begin
            c.sample_period = '1;
            c.press_count   = kda_pkg::THRESH_W'($urandom_range(1, 254));
            c.repeat_count  = kda_pkg::THRESH_W'($urandom_range(2, 255));
            c.release_count = kda_pkg::THRESH_W'($urandom_range(1, 255));
         end
      endcase
      return c;
   endfunction

   // key strokes sized to the current settings: chatter, hold, chatter, let go;
   // some holds stop short of a press, now and then plain noise slips in
   function automatic void queue_key_strokes(input int unsigned budget);
      int unsigned spt;
      int unsigned peak;
      int unsigned hold_span;
      int unsigned gap_span;
      int unsigned first;
      logic        pressed_level;
      spt  = (key_cfg.sample_period == 0) ? 1 : key_cfg.sample_period;
      peak = (key_cfg.press_count > key_cfg.repeat_count) ? key_cfg.press_count
                                                           : key_cfg.repeat_count;
      first = words_queued;
      // timer that never runs out: noise is all there is to send
      if (spt > 1000) begin
         repeat (budget) queue_pin(1'($urandom_range(0, 1)));
         return;
      end
      hold_span = spt * (peak + 4);
      gap_span  = spt * (key_cfg.release_count + 3);
      if (hold_span > 1200) hold_span = 1200;
      if (gap_span > 1200) gap_span = 1200;
      pressed_level = !key_cfg.active_low;
      while (words_queued - first < budget) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 8)) queue_pin(1'($urandom_range(0, 1)));
         queue_chatter();
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, hold_span)) queue_pin(pressed_level);
         else
            repeat ($urandom_range(hold_span / 2 + 1, hold_span * 2)) queue_pin(pressed_level);
         queue_chatter();
         repeat ($urandom_range(1, gap_span * 2)) queue_pin(!pressed_level);
      end
   endfunction

   // block idle: every word taken, every event back, pipeline drained
   task automatic settle();
      while (words_accepted != words_queued || predicted_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random_phase(input profile_type profile, input int unsigned budget);
      program_registers(pick_settings(profile));
      queue_key_strokes(budget);
      settle();
   endtask

   initial begin : sequencer
      kda_pkg::kda_cfg_type c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset values, then a few ticks with the reset settings
      check_registers();
      queue_bits(32'h0000_000E, 4);
      settle();

      // zero period, active high, highest code: press, repeats, an edge on
      // top of an expiry, then release
      c = '{active_low: 1'b0, report_code: 10'h3FF, sample_period: 16'd0,
            press_count: 8'd1, repeat_count: 8'd3, release_count: 8'd2};
      program_registers(c);
      queue_bits(32'h0000_006F, 11);
      settle();

      // active low, code zero: release count reached while a repeat is
      // reported, so the timer stays off until the next edge
      c = '{active_low: 1'b1, report_code: 10'h000, sample_period: 16'd1,
            press_count: 8'd1, repeat_count: 8'd2, release_count: 8'd1};
      program_registers(c);
      csr_write(REG_SPARE, $urandom());
      check_registers();
      queue_bits(32'h0000_0134, 9);
      settle();

      run_random_phase(PROF_SHORT,   95);
      run_random_phase(PROF_SKEWED,  95);
      run_random_phase(PROF_FLOOR,   95);
      run_random_phase(PROF_SLOW,    95);
      run_random_phase(PROF_CEILING, 300);
      run_random_phase(PROF_SHORT,   95);
      run_random_phase(PROF_LONGEST, 40);
      run_random_phase(PROF_SKEWED,  95);
      run_random_phase(PROF_SHORT,   95);
      run_random_phase(PROF_FLOOR,   95);
      run_random_phase(PROF_SLOW,    95);
      run_random_phase(PROF_SKEWED,  95);
      run_random_phase(PROF_SHORT,   95);
      run_random_phase(PROF_SKEWED,  95);

      // stray words would show up as unpredicted here
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && predicted_events.size() == 0)
         $display("key_debounce_autorepeat_core test passed");
      else
         $display("key_debounce_autorepeat_core test failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("key_debounce_autorepeat_core test failed");
      $finish;
   end

endmodule
